// File: hw/rtl/sacm_pkg.sv
package sacm_pkg;

  localparam int unsigned AddrW    = 48;
  localparam int unsigned CountW   = 10;
  localparam int unsigned CntW     = 32;
  localparam int unsigned CmdCntW  = 16;
  localparam int unsigned MaxLines = 16;
  localparam int unsigned NumW     = 5;

  localparam logic [1:0] CFG_REPLACEMENT_MODE = 2'd0;
  localparam logic [1:0] CFG_STORE_ALLOCATE   = 2'd1;

  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_ROUND  = 2'd1;
  localparam logic [1:0] MODE_LRU    = 2'd2;

  localparam int unsigned CNT_LOAD_HIT   = 0;
  localparam int unsigned CNT_LOAD_MISS  = 1;
  localparam int unsigned CNT_STORE_HIT  = 2;
  localparam int unsigned CNT_STORE_MISS = 3;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_RESP
  } back_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [AddrW-1:0]  byte_address;
    logic [CountW-1:0] byte_count;
    logic              is_store;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0]   line_address;
    logic               line_hit;
    logic               next_level_request;
    logic               all_hit;
    logic               last_result;
    logic [CntW-1:0]    load_hit_total;
    logic [CntW-1:0]    load_miss_total;
    logic [CntW-1:0]    store_hit_total;
    logic [CntW-1:0]    store_miss_total;
    logic [CmdCntW-1:0] flush_total;
    logic [CmdCntW-1:0] reset_total;
  } out_item_t;

  typedef struct packed {
    cmd_e             cmd;
    logic             is_store;
    logic [AddrW-1:0] first_line;
    logic [NumW-1:0]  line_count;
  } job_t;

endpackage

// File: hw/rtl/sacm_ram.sv
module sacm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/sacm_queue.sv
module sacm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sacm_pkg::job_t   push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output sacm_pkg::job_t   pop_data_o,
  output logic             empty_o
);
  import sacm_pkg::*;

  job_t       slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = slot_q[rptr_q];
  assign full_o     = fill_q[1];
  assign empty_o    = (fill_q == 2'd0);

endmodule

// File: hw/rtl/sacm_front.sv
module sacm_front #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sacm_pkg::in_item_t in_item_i,
  input  logic               busy_i,
  input  logic               full_i,
  output logic               push_o,
  output sacm_pkg::job_t     job_o
);
  import sacm_pkg::*;

  localparam int unsigned LbBits = $clog2(LINE_BYTES);

  logic [AddrW:0] first_line;
  logic [AddrW:0] end_byte;
  logic [AddrW:0] last_line;
  logic [AddrW:0] span;
  logic           cmd_ok;

  always_comb begin
    first_line = {1'b0, in_item_i.byte_address} >> LbBits;
    end_byte   = {1'b0, in_item_i.byte_address}
               + {{(AddrW + 1 - CountW){1'b0}}, in_item_i.byte_count}
               - {{AddrW{1'b0}}, 1'b1};
    last_line  = (in_item_i.byte_count == '0) ? first_line : (end_byte >> LbBits);
    span       = last_line - first_line;
  end

  always_comb begin
    job_o.cmd        = cmd_e'(in_item_i.cmd);
    job_o.is_store   = in_item_i.is_store;
    job_o.first_line = first_line[AddrW-1:0];
    if (span >= (AddrW + 1)'(MaxLines - 1)) begin
      job_o.line_count = NumW'(MaxLines);
    end else begin
      job_o.line_count = span[NumW-1:0] + NumW'(1);
    end
  end

  assign cmd_ok     = (in_item_i.cmd == CMD_ACCESS) || (in_item_i.cmd == CMD_FLUSH)
                   || (in_item_i.cmd == CMD_CLEAR);
  assign in_ready_o = !busy_i && !full_i;
  assign push_o     = in_valid_i && in_ready_o && cmd_ok;

endmodule

// File: hw/rtl/sacm_back.sv
module sacm_back #(
  parameter int unsigned LINE_BYTES = 64,
  parameter int unsigned SET_COUNT  = 64,
  parameter int unsigned WAY_COUNT  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          mode_i,
  input  logic                store_allocate_i,
  input  logic                empty_i,
  input  sacm_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sacm_pkg::out_item_t out_item_o
);
  import sacm_pkg::*;

  localparam int unsigned LbBits  = $clog2(LINE_BYTES);
  localparam int unsigned SetBits = $clog2(SET_COUNT);
  localparam int unsigned SetW    = (SET_COUNT > 1) ? SetBits : 1;
  localparam int unsigned LineW   = AddrW - LbBits;
  localparam int unsigned TagW    = LineW - SetBits;
  localparam int unsigned RankW   = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned ValOff  = WAY_COUNT * TagW;
  localparam int unsigned RankOff = ValOff + WAY_COUNT;
  localparam int unsigned PtrOff  = RankOff + WAY_COUNT * RankW;
  localparam int unsigned RowW    = PtrOff + RankW;

  back_state_e state_q, state_d;

  logic [SetW-1:0]    sweep_q, sweep_d;
  logic               flush_q, flush_d;
  logic [LineW-1:0]   line_q, line_d;
  logic [NumW-1:0]    left_q, left_d;
  logic               store_q, store_d;
  logic               allhit_q, allhit_d;
  logic [CntW-1:0]    cnt_q [4];
  logic [CntW-1:0]    cnt_d [4];
  logic [CmdCntW-1:0] flushes_q, flushes_d, resets_q, resets_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               slot_free;
  logic               ram_we, ram_re;
  logic [SetW-1:0]    ram_waddr;
  logic [RowW-1:0]    ram_wdata, row, row_new, row_init;
  logic [SetW-1:0]    set_idx;
  logic [TagW-1:0]    tag;

  logic [TagW-1:0]    way_tag  [WAY_COUNT];
  logic               way_val  [WAY_COUNT];
  logic [RankW-1:0]   way_rank [WAY_COUNT];
  logic [RankW-1:0]   ptr, ptr_new;
  logic               hit, alloc, do_recent;
  logic [RankW-1:0]   found, victim, target;
  logic [RankW-1:0]   best_rank;
  logic               last_line;
  logic [1:0]         cnt_sel;

  assign set_idx   = (SET_COUNT > 1) ? SetW'(line_q) : '0;
  assign tag       = TagW'(line_q >> SetBits);
  assign slot_free = !out_valid_q || out_ready_i;
  assign last_line = (left_q == NumW'(1));

  sacm_ram #(
    .WIDTH(RowW),
    .DEPTH(SET_COUNT)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(set_idx),
    .rdata_o(row)
  );

  always_comb begin
    row_init = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      row_init[RankOff + w * RankW +: RankW] = RankW'(w);
    end
    row_init[PtrOff +: RankW] = RankW'(WAY_COUNT - 1);
  end

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      way_tag[w]  = row[w * TagW +: TagW];
      way_val[w]  = row[ValOff + w];
      way_rank[w] = row[RankOff + w * RankW +: RankW];
    end
    ptr = row[PtrOff +: RankW];

    hit   = 1'b0;
    found = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (way_val[w] && (way_tag[w] == tag) && ((mode_i != MODE_DIRECT) || (w == 0))) begin
        hit   = 1'b1;
        found = RankW'(w);
      end
    end

    victim    = '0;
    best_rank = way_rank[0];
    for (int w = 1; w < WAY_COUNT; w++) begin
      if (way_rank[w] > best_rank) begin
        best_rank = way_rank[w];
        victim    = RankW'(w);
      end
    end

    alloc   = !hit && (!store_q || store_allocate_i);
    ptr_new = ptr;
    if (hit) begin
      target = found;
    end else if (mode_i == MODE_DIRECT) begin
      target = '0;
    end else if (mode_i == MODE_ROUND) begin
      target = ptr;
      if (alloc) begin
        ptr_new = (ptr == '0) ? RankW'(WAY_COUNT - 1) : ptr - RankW'(1);
      end
    end else begin
      target = victim;
    end
    do_recent = mode_i[1] && (hit || alloc);

    row_new = row;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (do_recent) begin
        if (RankW'(w) == target) begin
          row_new[RankOff + w * RankW +: RankW] = '0;
        end else if (way_rank[w] < way_rank[target]) begin
          row_new[RankOff + w * RankW +: RankW] = way_rank[w] + RankW'(1);
        end
      end
      if (alloc && (RankW'(w) == target)) begin
        row_new[w * TagW +: TagW] = tag;
        row_new[ValOff + w]       = 1'b1;
      end
    end
    row_new[PtrOff +: RankW] = ptr_new;

    cnt_sel = {store_q, !hit};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (sweep_q == SetW'(SET_COUNT - 1)) begin
          state_d = flush_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          unique case (job_i.cmd)
            CMD_ACCESS: state_d = ST_READ;
            CMD_FLUSH:  state_d = ST_SWEEP;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (slot_free) begin
          state_d = last_line ? ST_IDLE : ST_READ;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sweep_d     = sweep_q;
    flush_d     = flush_q;
    line_d      = line_q;
    left_d      = left_q;
    store_d     = store_q;
    allhit_d    = allhit_q;
    cnt_d       = cnt_q;
    flushes_d   = flushes_q;
    resets_d    = resets_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = set_idx;
    ram_wdata   = row_new;
    unique case (state_q)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = row_init;
        sweep_d   = sweep_q + SetW'(1);
        if (sweep_q == SetW'(SET_COUNT - 1)) begin
          sweep_d = '0;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o    = 1'b1;
          line_d   = LineW'(job_i.first_line);
          left_d   = job_i.line_count;
          store_d  = job_i.is_store;
          allhit_d = 1'b1;
          unique case (job_i.cmd)
            CMD_ACCESS: ;
            CMD_FLUSH: begin
              flush_d = 1'b1;
              if (flushes_q != '1) begin
                flushes_d = flushes_q + CmdCntW'(1);
              end
            end
            default: begin
              for (int i = 0; i < 4; i++) begin
                cnt_d[i] = '0;
              end
              if (resets_q != '1) begin
                resets_d = resets_q + CmdCntW'(1);
              end
            end
          endcase
        end
      end
      ST_READ: ram_re = 1'b1;
      ST_EXEC: begin
        if (slot_free) begin
          ram_we = 1'b1;
          if (cnt_q[cnt_sel] != '1) begin
            cnt_d[cnt_sel] = cnt_q[cnt_sel] + CntW'(1);
          end
          allhit_d                 = allhit_q && hit;
          out_valid_d              = 1'b1;
          out_d.line_address       = {line_q, {LbBits{1'b0}}};
          out_d.line_hit           = hit;
          out_d.next_level_request = alloc;
          out_d.all_hit            = last_line && allhit_q && hit;
          out_d.last_result        = last_line;
          out_d.load_hit_total     = cnt_d[CNT_LOAD_HIT];
          out_d.load_miss_total    = cnt_d[CNT_LOAD_MISS];
          out_d.store_hit_total    = cnt_d[CNT_STORE_HIT];
          out_d.store_miss_total   = cnt_d[CNT_STORE_MISS];
          out_d.flush_total        = flushes_q;
          out_d.reset_total        = resets_q;
          line_d                   = line_q + LineW'(1);
          left_d                   = left_q - NumW'(1);
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          flush_d                  = 1'b0;
          out_valid_d              = 1'b1;
          out_d.line_address       = '0;
          out_d.line_hit           = 1'b0;
          out_d.next_level_request = 1'b0;
          out_d.all_hit            = 1'b0;
          out_d.last_result        = 1'b1;
          out_d.load_hit_total     = cnt_q[CNT_LOAD_HIT];
          out_d.load_miss_total    = cnt_q[CNT_LOAD_MISS];
          out_d.store_hit_total    = cnt_q[CNT_STORE_HIT];
          out_d.store_miss_total   = cnt_q[CNT_STORE_MISS];
          out_d.flush_total        = flushes_q;
          out_d.reset_total        = resets_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      flush_q     <= 1'b0;
      left_q      <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt_q[i] <= '0;
      end
      flushes_q   <= '0;
      resets_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      flush_q     <= flush_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      flushes_q   <= flushes_d;
      resets_q    <= resets_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q   <= line_d;
    store_q  <= store_d;
    allhit_q <= allhit_d;
    out_q    <= out_d;
  end

  assign busy_o      = (state_q == ST_SWEEP) && !flush_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hw/rtl/set_assoc_cache_tag_model.sv
// Tag-only set-associative cache level with hit and miss statistics.
// Input beats carry a command: an access over a byte range, a flush of all
// lines, or a reset of the hit and miss counters. An access yields one output
// beat per cache line touched, at most sixteen, the final one marked
// last_result; flush and counter reset yield a single beat each.
// The front end classifies a beat and places it in a two-entry queue in the
// same cycle. For each line the back end first reads the set's row (tags,
// valid bits, ranks, victim pointer) from the tag memory, then compares,
// updates the row and registers the result. An access passes from the queue
// through the IDLE, READ and EXEC states to the output register; a flush
// rewrites the row of every set before its beat.
// After reset the tag memory is cleared row by row, during which in_ready_o
// is low; configuration writes are taken at any time.
// When out_ready_i is low the result is held in the output register, the back
// end stops, and the queue goes on taking beats until it is full.
module set_assoc_cache_tag_model #(
  parameter int unsigned LINE_BYTES = 64,
  parameter int unsigned SET_COUNT  = 64,
  parameter int unsigned WAY_COUNT  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [1:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sacm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sacm_pkg::out_item_t out_item_o
);
  import sacm_pkg::*;

  logic [1:0] mode_q, mode_d;
  logic       alloc_q, alloc_d;
  logic       busy, full, empty, push, pop;
  job_t       push_job, pop_job;

  always_comb begin
    mode_d  = mode_q;
    alloc_d = alloc_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REPLACEMENT_MODE: mode_d  = cfg_data_i;
        CFG_STORE_ALLOCATE:   alloc_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LRU;
      alloc_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      alloc_q <= alloc_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  sacm_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i (in_item_i),
    .busy_i    (busy),
    .full_i    (full),
    .push_o    (push),
    .job_o     (push_job)
  );

  sacm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_job),
    .empty_o    (empty)
  );

  sacm_back #(
    .LINE_BYTES(LINE_BYTES),
    .SET_COUNT (SET_COUNT),
    .WAY_COUNT (WAY_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_q),
    .store_allocate_i(alloc_q),
    .empty_i         (empty),
    .job_i           (pop_job),
    .pop_o           (pop),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_item_o      (out_item_o)
  );

endmodule
